>>> src/ida_pkg.sv
`timescale 1ns / 1ps

package ida_pkg;

   // Field widths of the request and result words
   localparam int ID_W      = 10;
   localparam int KIND_W    = 2;
   localparam int TDATA_W   = 16;

   // Bitmap storage: 32 IDs per map word, IDs above 1023 are never reachable
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;
   localparam int ID_LIMIT  = 1024;
   localparam int ID_COUNT_DEFAULT = 1024;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MARK  = 2'd2;

   // One map word: freed-but-not-reused bits and in-use bits for 32 IDs
   typedef struct packed {
      logic [WORD_BITS-1:0] rel_bits;
      logic [WORD_BITS-1:0] used_bits;
   } map_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_DECIDE,
      ST_WRITE,
      ST_RESP
   } state_type;

   // Position of the lowest set bit of a word (0 when the word is empty)
   function automatic logic [BIT_W-1:0] low_one(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

   // Position of the highest set bit of a word (0 when the word is empty)
   function automatic logic [BIT_W-1:0] high_one(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (w[i]) begin
            pos = BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

>>> src/ida_map.sv
`timescale 1ns / 1ps

module ida_map
   import ida_pkg::*;
#(
   parameter int WORDS  = 32,
   parameter int ADDR_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output map_word_type       rd_data,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  map_word_type       wr_data
);

   map_word_type           mem_ff [WORDS];
   logic [WORDS-1:0]       vld_ff;
   map_word_type           rd_data_ff;

   // Track which words have been written since reset; unwritten words read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/id_allocator.sv
`timescale 1ns / 1ps

// ID allocator: hands out IDs 0 .. highest_id from two bitmaps (in use, freed).
// Request channel req_*: req_tuser is the kind (allocate, free, mark used),
// req_tdata[9:0] the ID for free and mark used. One result word per request on
// rsp_*: rsp_tdata[9:0] is the allocated or requested ID, rsp_tuser the ok flag.
// csr_we/csr_wdata write highest_id (0 selects min(ID_COUNT,1024)-1); write only when idle.
// The maps sit in one memory of WORDS = ceil(min(ID_COUNT,1024)/32) words,
// each holding the freed and in-use bits of 32 IDs, one read port.
// Allocate: one pass reads every map word through the word scanner, then a
// read-modify-write of the chosen word; when no ID can be given, the result
// is given with no write. Free and mark used: a single read-modify-write;
// an out-of-range ID or an unknown kind is answered with no memory access.
// One request is in work at a time; req_tready is high only when idle.
// A result waits in the output register while rsp_tready is low; the next
// request is still taken, and its result holds until the output is free.
// Reset clears one valid bit per map word, so both maps read as empty at once,
// with no clearing pass; highest_id returns to 0.
module id_allocator
   import ida_pkg::*;
#(
   parameter int ID_COUNT = ID_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   // request word
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TDATA_W-1:0]  req_tdata,   // [9:0] id
   input  logic [KIND_W-1:0]   req_tuser,   // [1:0] kind
   // result word
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TDATA_W-1:0]  rsp_tdata,   // [9:0] result_id
   output logic                rsp_tuser,   // [0] ok
   // configuration
   input  logic                csr_we,
   input  logic [ID_W-1:0]     csr_wdata
);

   localparam int MAP_IDS = (ID_COUNT > ID_LIMIT) ? ID_LIMIT : ID_COUNT;
   localparam int WORDS   = (MAP_IDS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [ID_W-1:0] ID_TOP = ID_W'(MAP_IDS - 1);

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      scan_ff, scan_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [ADDR_W-1:0]      chk_idx_ff, chk_idx_in;
   logic                   rel_found_ff, rel_found_in;
   logic [ID_W-1:0]        rel_pos_ff, rel_pos_in;
   logic                   used_found_ff, used_found_in;
   logic [ID_W-1:0]        used_hi_ff, used_hi_in;
   logic                   gap_found_ff, gap_found_in;
   logic [ID_W-1:0]        gap_pos_ff, gap_pos_in;
   logic [KIND_W-1:0]      op_kind_ff, op_kind_in;
   logic [ID_W-1:0]        op_id_ff, op_id_in;
   logic [ID_W-1:0]        res_id_ff, res_id_in;
   logic                   res_ok_ff, res_ok_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [ID_W-1:0]        highest_ff;

   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   map_word_type           rd_data;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   map_word_type           wr_data;

   logic [ID_W-1:0]        max_id;
   logic [ID_W-1:0]        req_id;
   logic                   req_fire;
   logic                   out_free;
   logic [ID_W:0]          cand;
   logic                   cand_found;
   logic                   cand_ok;
   logic [BIT_W-1:0]       bit_sel;

   ida_map #(
      .WORDS  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Effective highest ID
   always_comb begin
      if (highest_ff != '0 && highest_ff < ID_TOP) begin
         max_id = highest_ff;
      end else begin
         max_id = ID_TOP;
      end
   end

   assign req_id     = req_tdata[ID_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign bit_sel    = op_id_ff[BIT_W-1:0];

   // Pick the allocation candidate from the scan results
   always_comb begin
      cand       = '0;
      cand_found = 1'b1;
      if (rel_found_ff) begin
         cand = {1'b0, rel_pos_ff};
      end else if (used_found_ff) begin
         if (used_hi_ff == max_id) begin
            cand_found = gap_found_ff && (gap_pos_ff < used_hi_ff);
            cand       = {1'b0, gap_pos_ff};
         end else begin
            cand = {1'b0, used_hi_ff} + (ID_W+1)'(1);
         end
      end
      cand_ok = cand_found && (cand <= {1'b0, max_id});
   end

   // Sequencer: next state, memory controls, scan and result updates
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      rel_found_in  = rel_found_ff;
      rel_pos_in    = rel_pos_ff;
      used_found_in = used_found_ff;
      used_hi_in    = used_hi_ff;
      gap_found_in  = gap_found_ff;
      gap_pos_in    = gap_pos_ff;
      op_kind_in    = op_kind_ff;
      op_id_in      = op_id_ff;
      res_id_in     = res_id_ff;
      res_ok_in     = res_ok_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_ok_in     = rsp_ok_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = ADDR_W'(op_id_ff[ID_W-1:BIT_W]);
      wr_data       = rd_data;

      // Fold the word read in the previous cycle into the scan results
      if (chk_vld_ff) begin
         if (!rel_found_ff && (|rd_data.rel_bits)) begin
            rel_found_in = 1'b1;
            rel_pos_in   = ID_W'({chk_idx_ff, low_one(rd_data.rel_bits)});
         end
         if (|rd_data.used_bits) begin
            used_found_in = 1'b1;
            used_hi_in    = ID_W'({chk_idx_ff, high_one(rd_data.used_bits)});
         end
         if (!gap_found_ff && (|(~rd_data.used_bits))) begin
            gap_found_in = 1'b1;
            gap_pos_in   = ID_W'({chk_idx_ff, low_one(~rd_data.used_bits)});
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_kind_in = req_tuser;
               op_id_in   = req_id;
               res_id_in  = req_id;
               res_ok_in  = 1'b0;
               if (req_tuser == KIND_ALLOC) begin
                  scan_in       = '0;
                  rel_found_in  = 1'b0;
                  used_found_in = 1'b0;
                  gap_found_in  = 1'b0;
                  state_in      = ST_SCAN;
               end else if ((req_tuser == KIND_FREE || req_tuser == KIND_MARK) &&
                            req_id <= max_id) begin
                  rd_en    = 1'b1;
                  rd_addr  = ADDR_W'(req_id[ID_W-1:BIT_W]);
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            rd_en      = 1'b1;
            rd_addr    = scan_ff;
            chk_vld_in = 1'b1;
            chk_idx_in = scan_ff;
            if (scan_ff == ADDR_W'(WORDS - 1)) begin
               state_in = ST_TAIL;
            end else begin
               scan_in = scan_ff + ADDR_W'(1);
            end
         end
         ST_TAIL: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (cand_ok) begin
               op_id_in = cand[ID_W-1:0];
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(cand[ID_W-1:BIT_W]);
               state_in = ST_WRITE;
            end else begin
               res_id_in = '0;
               res_ok_in = 1'b0;
               state_in  = ST_RESP;
            end
         end
         ST_WRITE: begin
            wr_en     = 1'b1;
            res_id_in = op_id_ff;
            res_ok_in = 1'b0;
            case (op_kind_ff)
               KIND_ALLOC: begin
                  wr_data.used_bits[bit_sel] = 1'b1;
                  wr_data.rel_bits[bit_sel]  = 1'b0;
                  res_ok_in                  = 1'b1;
               end
               KIND_FREE: begin
                  if (rd_data.used_bits[bit_sel]) begin
                     wr_data.used_bits[bit_sel] = 1'b0;
                     wr_data.rel_bits[bit_sel]  = 1'b1;
                     res_ok_in                  = 1'b1;
                  end
               end
               KIND_MARK: begin
                  wr_data.rel_bits[bit_sel] = 1'b0;
                  if (!rd_data.used_bits[bit_sel]) begin
                     wr_data.used_bits[bit_sel] = 1'b1;
                     res_ok_in                  = 1'b1;
                  end
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // Hold the result until the output register is free
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_id_in  = res_id_ff;
               rsp_ok_in  = res_ok_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_vld_ff    <= 1'b0;
         rel_found_ff  <= 1'b0;
         used_found_ff <= 1'b0;
         gap_found_ff  <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         highest_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         rel_found_ff  <= rel_found_in;
         used_found_ff <= used_found_in;
         gap_found_ff  <= gap_found_in;
         rsp_vld_ff    <= rsp_vld_in;
         if (csr_we) begin
            highest_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      rel_pos_ff <= rel_pos_in;
      used_hi_ff <= used_hi_in;
      gap_pos_ff <= gap_pos_in;
      op_kind_ff <= op_kind_in;
      op_id_ff   <= op_id_in;
      res_id_ff  <= res_id_in;
      res_ok_ff  <= res_ok_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_ok_ff  <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = TDATA_W'(rsp_id_ff);
   assign rsp_tuser  = rsp_ok_ff;

endmodule

>>> src/ida_checker.sv
`timescale 1ns / 1ps

module ida_checker
   import ida_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [TDATA_W-1:0]  rsp_tdata,
   input  logic                rsp_tuser
);

   // Reset empties the output register
   a_reset_clears_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word valid right after reset");

   // An accepted request leaves the block busy in the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

   // A new result appears only as the block finishes and returns to idle
   a_rsp_at_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready && !$past(req_tready))
      else $error("result word appeared outside request completion");

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

endmodule

bind id_allocator ida_checker u_ida_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
